### design/zctf_pkg.sv
// Package for the zero-crossing timestamp framer: widths, frame geometry
// and interpolation constants shared by the core, divider and slot memory.
// No dependencies.
package zctf_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LENGTH = 256;
  localparam int unsigned SLOT_COUNT   = 16;
  localparam int unsigned POS_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIMER_W    = 32;
  localparam int unsigned DIVIDER_W  = 16;
  localparam int unsigned SLOT_NUM_W = 4;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned TIME_W     = 32;

  // Interpolation: num = sample * scale, den = divider * (sample - previous)
  localparam int unsigned MICROS_SCALE = 1000000;
  localparam int unsigned SCALE_W      = $clog2(MICROS_SCALE + 1);
  localparam int unsigned NUM_W        = SAMPLE_W - 1 + SCALE_W;
  localparam int unsigned DEN_W        = DIVIDER_W + SAMPLE_W;
  localparam int unsigned DIV_CNT_W    = $clog2(NUM_W + 1);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;

endpackage

### design/zero_cross_timestamp_framer_core.sv
// Each request moves through ST_IDLE, ST_MUL and ST_DONE; a sample that completes
// a rising zero crossing also waits in ST_WAIT for the 35-step serial divider.
// The core takes a new request only once the last one has left ST_DONE for the
// output register. Asynchronous active-low reset clears the frame position,
// slot, previous sample and the slot store valid bits; pll_divider resets to 1.
// No clearing pass is needed after reset.
module zero_cross_timestamp_framer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: pll_divider
  input  logic                            cfg_we_i,
  input  logic [zctf_pkg::DIVIDER_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] sample, [47:16] timer_count
  input  logic [zctf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] slot_number, [11:4] sample_index, [27:12] sample_value,
  // [59:28] crossing_time, [63:60] zero
  output logic [zctf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] crossing_found
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [zctf_pkg::DIVIDER_W-1:0]  pll_div_q;
  logic [zctf_pkg::SAMPLE_W-1:0]   prev_q;
  logic [zctf_pkg::POS_W-1:0]      pos_q;
  logic [zctf_pkg::SLOT_W-1:0]     slot_q;
  logic [zctf_pkg::SAMPLE_W-1:0]   sample_q;
  logic [zctf_pkg::TIMER_W-1:0]    timer_q;
  logic                            cross_q;
  logic [zctf_pkg::NUM_W-1:0]      num_q;
  logic [zctf_pkg::DEN_W-1:0]      den_q;
  logic                            start_q;
  logic [zctf_pkg::TIME_W-1:0]     time_q;
  logic                            out_vld_q;
  logic [zctf_pkg::SLOT_NUM_W-1:0] out_slot_q;
  logic [zctf_pkg::INDEX_W-1:0]    out_index_q;
  logic [zctf_pkg::SAMPLE_W-1:0]   out_sample_q;
  logic [zctf_pkg::TIME_W-1:0]     out_time_q;
  logic                            out_found_q;
  logic                            out_last_q;

  logic                            in_acc;
  logic                            fin;
  logic                            last;
  logic [zctf_pkg::SAMPLE_W-1:0]   in_sample;
  logic [zctf_pkg::TIMER_W-1:0]    in_timer;
  logic [zctf_pkg::DIVIDER_W-1:0]  div_eff;
  logic [zctf_pkg::SAMPLE_W:0]     diff_full;
  logic [zctf_pkg::NUM_W-1:0]      num_d;
  logic [zctf_pkg::DEN_W-1:0]      den_d;
  logic [zctf_pkg::TIME_W-1:0]     mem_rdata;
  logic                            mem_we;
  logic                            div_busy;
  logic                            div_done;
  logic [zctf_pkg::NUM_W-1:0]      div_quo;

  assign in_sample = s_axis_tdata_i[zctf_pkg::SAMPLE_W-1:0];
  assign in_timer  = s_axis_tdata_i[zctf_pkg::SAMPLE_W +: zctf_pkg::TIMER_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign fin             = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);
  assign mem_we          = fin && cross_q;
  assign last            = (pos_q == zctf_pkg::POS_W'(zctf_pkg::FRAME_LENGTH - 1));

  // interpolation operands; only used on a crossing, where sample >= 0
  assign div_eff   = (pll_div_q == '0) ? zctf_pkg::DIVIDER_W'(1) : pll_div_q;
  assign diff_full = {sample_q[zctf_pkg::SAMPLE_W-1], sample_q}
                   - {prev_q[zctf_pkg::SAMPLE_W-1], prev_q};
  assign num_d     = zctf_pkg::NUM_W'(sample_q[zctf_pkg::SAMPLE_W-2:0])
                   * zctf_pkg::NUM_W'(zctf_pkg::MICROS_SCALE);
  assign den_d     = zctf_pkg::DEN_W'(div_eff)
                   * zctf_pkg::DEN_W'(diff_full[zctf_pkg::SAMPLE_W-1:0]);

  zctf_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (slot_q),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (slot_q),
    .wr_data_i (time_q)
  );

  zctf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pll_div_q    <= zctf_pkg::DIVIDER_W'(1);
      prev_q       <= '0;
      pos_q        <= '0;
      slot_q       <= '0;
      sample_q     <= '0;
      timer_q      <= '0;
      cross_q      <= 1'b0;
      num_q        <= '0;
      den_q        <= '0;
      start_q      <= 1'b0;
      time_q       <= '0;
      out_vld_q    <= 1'b0;
      out_slot_q   <= '0;
      out_index_q  <= '0;
      out_sample_q <= '0;
      out_time_q   <= '0;
      out_found_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        pll_div_q <= cfg_wdata_i;
      end
      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sample_q <= in_sample;
            timer_q  <= in_timer;
            cross_q  <= prev_q[zctf_pkg::SAMPLE_W-1] && !in_sample[zctf_pkg::SAMPLE_W-1];
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          num_q  <= num_d;
          den_q  <= den_d;
          time_q <= mem_rdata;
          if (cross_q) begin
            start_q <= 1'b1;
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            time_q  <= timer_q - div_quo[zctf_pkg::TIME_W-1:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (fin) begin
            out_slot_q   <= zctf_pkg::SLOT_NUM_W'(slot_q);
            out_index_q  <= zctf_pkg::INDEX_W'(pos_q);
            out_sample_q <= sample_q;
            out_time_q   <= time_q;
            out_found_q  <= cross_q;
            out_last_q   <= last;
            prev_q       <= sample_q;
            if (last) begin
              pos_q  <= '0;
              slot_q <= (slot_q == zctf_pkg::SLOT_W'(zctf_pkg::SLOT_COUNT - 1))
                        ? '0 : slot_q + 1'b1;
            end else begin
              pos_q <= pos_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_time_q, out_sample_q, out_index_q, out_slot_q};
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is still in flight");

  a_no_accept_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("ready raised while divider busy");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT))
    else $error("divider finished outside the wait state");

  a_write_on_crossing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cross_q && $past(state_q) == ST_DONE || $past(state_q) == ST_WAIT
                || $past(state_q) == ST_MUL))
    else $error("slot store written without a crossing result");

  a_done_starts_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> m_axis_tvalid_o)
    else $error("finished item not presented on output");
`endif

endmodule

### design/zctf_div.sv
// Restoring divider for the crossing interpolation, one quotient bit a cycle.
// Depends on zctf_pkg.
module zctf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [zctf_pkg::NUM_W-1:0] num_i,
  input  logic [zctf_pkg::DEN_W-1:0] den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [zctf_pkg::NUM_W-1:0] quo_o
);

  logic [zctf_pkg::NUM_W-1:0]     num_q, num_d;
  logic [zctf_pkg::DEN_W-1:0]     den_q;
  logic [zctf_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [zctf_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [zctf_pkg::DEN_W:0]       rem_sh;
  logic [zctf_pkg::DEN_W:0]       rem_sub;
  logic                           fits;

  // numerator shifts out at the top, quotient bits enter at the bottom
  always_comb begin
    rem_sh  = {rem_q, num_q[zctf_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = (rem_sh >= {1'b0, den_q});
    rem_d   = fits ? rem_sub[zctf_pkg::DEN_W-1:0] : rem_sh[zctf_pkg::DEN_W-1:0];
    num_d   = {num_q[zctf_pkg::NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= zctf_pkg::DIV_CNT_W'(zctf_pkg::NUM_W);
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == zctf_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

### design/zctf_slot_mem.sv
// Per-slot crossing time store: synchronous memory, one write and one read
// port, registered read data. Per-entry valid bits make unwritten slots read 0.
// Depends on zctf_pkg.
module zctf_slot_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [zctf_pkg::SLOT_W-1:0] rd_addr_i,
  output logic [zctf_pkg::TIME_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [zctf_pkg::SLOT_W-1:0] wr_addr_i,
  input  logic [zctf_pkg::TIME_W-1:0] wr_data_i
);

  logic [zctf_pkg::TIME_W-1:0]   mem_q [zctf_pkg::SLOT_COUNT];
  logic [zctf_pkg::SLOT_COUNT-1:0] vld_q;
  logic [zctf_pkg::TIME_W-1:0]   rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // only one item is in flight, so a read never meets a pending write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
